@@ rtl/sdf_pkg.sv @@
// Package for the sync-header packet deframer.
// Holds the phase and status codes, the sync constants and the result record.
// No dependencies.
package sdf_pkg;

	localparam logic [7:0] SYNC_S = 8'h73;
	localparam logic [7:0] SYNC_N = 8'h6E;
	localparam logic [7:0] SYNC_P = 8'h70;
	localparam logic [15:0] SYNC_SUM = 16'(SYNC_S) + 16'(SYNC_N) + 16'(SYNC_P);
	localparam logic [5:0] WORD_BYTES = 6'd4;

	localparam int TYPE_HAS_DATA_BIT = 7;
	localparam int TYPE_BATCH_BIT = 6;

	typedef enum logic [2:0] {
		PH_HUNT_S = 3'd0,
		PH_HUNT_N = 3'd1,
		PH_HUNT_P = 3'd2,
		PH_TYPE   = 3'd3,
		PH_DATA   = 3'd4,
		PH_SUM_HI = 3'd5,
		PH_SUM_LO = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY   = 2'd0,
		ST_GOOD   = 2'd1,
		ST_SEQERR = 2'd2,
		ST_SUMERR = 2'd3
	} status_t;

	typedef struct packed {
		status_t status;
		logic payload_valid;
		logic [5:0] payload_index;
		logic [7:0] payload_byte;
		logic [7:0] frame_type;
	} result_t;

endpackage

@@ rtl/sdf_if.sv @@
// Handshake channels of the sync-header packet deframer.
// Byte channel and result channel, each with source and sink modports.
// Depends on sdf_pkg.
interface sdf_byte_if;
	logic valid;
	logic ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface sdf_result_if import sdf_pkg::*; ;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic payload_valid;
	logic [5:0] payload_index;
	logic [7:0] payload_byte;
	logic [7:0] frame_type;

	modport source (output valid, output status, output payload_valid,
		output payload_index, output payload_byte, output frame_type, input ready);
	modport sink (input valid, input status, input payload_valid,
		input payload_index, input payload_byte, input frame_type, output ready);
endinterface

@@ rtl/sdf_core.sv @@
// Parser state machine of the sync-header packet deframer.
// Holds phase, checksum, type, count and length; steps once per request.
// Depends on sdf_pkg.
module sdf_core import sdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	output result_t    result
);

	phase_t phase_q, phase_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0] type_q, type_d;
	logic [5:0] count_q, count_d;
	logic [5:0] len_q, len_d;
	logic [7:0] sumhi_q, sumhi_d;
	logic [15:0] sum_plus;

	assign sum_plus = sum_q + 16'(byte_in);

	always_comb begin
		phase_d = PH_HUNT_S;
		sum_d = sum_q;
		type_d = type_q;
		count_d = count_q;
		len_d = len_q;
		sumhi_d = sumhi_q;
		case (phase_q)
			PH_HUNT_S: begin
				if (byte_in == SYNC_S) phase_d = PH_HUNT_N;
			end
			PH_HUNT_N: begin
				if (byte_in == SYNC_N) phase_d = PH_HUNT_P;
			end
			PH_HUNT_P: begin
				if (byte_in == SYNC_P) begin
					phase_d = PH_TYPE;
					sum_d = SYNC_SUM;
				end
			end
			PH_TYPE: begin
				type_d = byte_in;
				sum_d = sum_plus;
				if (!byte_in[TYPE_HAS_DATA_BIT]) begin
					phase_d = PH_SUM_HI;
				end else begin
					phase_d = PH_DATA;
					count_d = '0;
					len_d = byte_in[TYPE_BATCH_BIT] ? {byte_in[5:2], 2'b00} : WORD_BYTES;
				end
			end
			PH_DATA: begin
				phase_d = (count_q == len_q) ? PH_SUM_HI : PH_DATA;
				count_d = count_q + 6'd1;
				sum_d = sum_plus;
			end
			PH_SUM_HI: begin
				phase_d = PH_SUM_LO;
				sumhi_d = byte_in;
			end
			default: begin
				phase_d = PH_HUNT_S;
			end
		endcase
	end

	always_comb begin
		result.status = ST_BUSY;
		result.payload_valid = 1'b0;
		result.payload_index = '0;
		result.payload_byte = '0;
		result.frame_type = type_d;
		case (phase_q)
			PH_HUNT_S: begin
				if (byte_in != SYNC_S) result.status = ST_SEQERR;
			end
			PH_HUNT_N: begin
				if (byte_in != SYNC_N) result.status = ST_SEQERR;
			end
			PH_HUNT_P: begin
				if (byte_in != SYNC_P) result.status = ST_SEQERR;
			end
			PH_TYPE: begin
				result.status = ST_BUSY;
			end
			PH_DATA: begin
				result.payload_valid = 1'b1;
				result.payload_index = count_q;
				result.payload_byte = byte_in;
			end
			PH_SUM_HI: begin
				result.status = ST_BUSY;
			end
			PH_SUM_LO: begin
				result.status = ({sumhi_q, byte_in} == sum_q) ? ST_GOOD : ST_SUMERR;
			end
			default: begin
				result.status = ST_SEQERR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_S;
			sum_q <= '0;
			type_q <= '0;
			count_q <= '0;
			len_q <= '0;
			sumhi_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q <= sum_d;
			type_q <= type_d;
			count_q <= count_d;
			len_q <= len_d;
			sumhi_q <= sumhi_d;
		end
	end

endmodule

@@ rtl/sync_header_packet_deframer_top.sv @@
// Top level of the sync-header packet deframer.
// Input byte register, parser state machine and result register.
// Depends on sdf_pkg, sdf_if and sdf_core.
//
//   Channel     Direction  Contents
//   byte_ch     sink       byte_in, one received byte per request
//   result_ch   source     status, payload_valid, payload_index, payload_byte, frame_type
//
// Every byte request gives exactly one result request, through the input register, the
// parser step and the result register. One byte is taken per cycle while the result is
// not stalled; the single parser step between the two registers sets that rate.
// Reset clears the parser to hunting for the first sync byte and empties both registers.
// A stalled result holds both registers; a new byte is still taken while a free slot remains.
module sync_header_packet_deframer_top import sdf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	sdf_byte_if.sink    byte_ch,
	sdf_result_if.source result_ch
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic valid_s2;
	result_t result_s2;
	result_t step_result;
	logic advance;

	assign advance = !valid_s2 || result_ch.ready;
	assign byte_ch.ready = !valid_s1 || advance;

	sdf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.byte_in (byte_s1),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (byte_ch.ready) valid_s1 <= byte_ch.valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) byte_s1 <= byte_ch.byte_in;
		if (advance && valid_s1) result_s2 <= step_result;
	end

	assign result_ch.valid = valid_s2;
	assign result_ch.status = result_s2.status;
	assign result_ch.payload_valid = result_s2.payload_valid;
	assign result_ch.payload_index = result_s2.payload_index;
	assign result_ch.payload_byte = result_s2.payload_byte;
	assign result_ch.frame_type = result_s2.frame_type;

endmodule

@@ rtl/sdf_checker.sv @@
// Port checker for the sync-header packet deframer, bound to the top level.
// Watches the result channel over time.
// Depends on sdf_pkg and sync_header_packet_deframer_top.
module sdf_checker import sdf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] status,
	input logic       payload_valid,
	input logic [5:0] payload_index,
	input logic [7:0] payload_byte
);

	// A result that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	// A payload byte never ends a frame.
	a_payload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && payload_valid |-> status == ST_BUSY)
		else $error("payload byte carries a final status");

	// The payload index stays within the longest frame.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && payload_valid |-> payload_index <= 6'd60)
		else $error("payload index out of range");

	// Outside payload the index and byte read as zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> payload_index == '0 && payload_byte == '0)
		else $error("payload fields set outside payload");

endmodule

bind sync_header_packet_deframer_top sdf_checker u_sdf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result_ch.valid),
	.res_ready     (result_ch.ready),
	.status        (result_ch.status),
	.payload_valid (result_ch.payload_valid),
	.payload_index (result_ch.payload_index),
	.payload_byte  (result_ch.payload_byte)
);
